// File: sv/jbp_pkg.sv
// Shared constants and types for the JPEG bit packer with byte stuffing.
package jbp_pkg;

    // Field widths fixed by the interface
    localparam int MODE_W  = 1;
    localparam int COUNT_W = 5;
    localparam int VALUE_W = 16;
    localparam int BYTE_W  = 8;

    // Default longest code, handed to the top level parameter
    localparam int MAX_CODE_BITS_DEF = 16;

    // Residual and padding
    localparam int RES_W     = 7;
    localparam int ACC_CNT_W = 3;
    localparam logic [ACC_CNT_W-1:0] ACC_FULL = 3'd7;
    localparam int PAD_BITS = 7;
    localparam logic [BYTE_W-1:0] PAD_VALUE = 8'h7f;

    // Stuffing
    localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hff;
    localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'h00;

    // Results per input transaction
    localparam int RESULT_W = 3;
    localparam logic [RESULT_W-1:0] RESULT_LIMIT = 3'd4;
    localparam logic [RESULT_W-1:0] RESULT_LAST  = 3'd3;

    // Input modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Packer sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_STUFF = 3'b100
    } jbp_state_t;

    // Write request from the packer into the output stage
    typedef struct packed {
        logic              wr;
        logic [BYTE_W-1:0] data;
        logic              last;
    } jbp_out_wr_t;

endpackage

// File: sv/jpeg_bit_packer_stuffing.sv
// Top level: bit-serial JPEG entropy bit packer with 0xFF byte stuffing.
// Throughput: one bit of code per cycle, held while a stuffed zero is written or the
//   output stage is stalled; the input is stalled until a write transaction (count
//   saturated to MAX_CODE_BITS) or a flush has shifted out all its bits; a zero-count
//   write does not stall the input.
// Output: a byte that completes on the last code bit is registered in the output stage
//   before it is offered at the output.
// Reset: rst_n clears the residual, the sequencer and the output valid at once.
module jpeg_bit_packer_stuffing
    import jbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [MODE_W-1:0]  mode,
    input  logic [COUNT_W-1:0] count,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               last
);

    // Code shift register is at least as wide as the value field
    localparam int SR_W = (MAX_CODE_BITS > VALUE_W) ? MAX_CODE_BITS : VALUE_W;
    localparam int RC_W = $clog2(SR_W + 1);
    localparam int RI_W = $clog2(SR_W);

    jbp_state_t            state_reg, state_next;
    logic [SR_W-1:0]       code_reg, code_next;
    logic [RC_W-1:0]       rem_reg, rem_next;
    logic                  flush_reg, flush_next;
    logic [RES_W-1:0]      acc_reg, acc_next;
    logic [ACC_CNT_W-1:0]  acc_cnt_reg, acc_cnt_next;
    logic [RESULT_W-1:0]   n_reg, n_next;

    jbp_out_wr_t           wr_req;
    logic                  out_free;

    logic [RC_W-1:0]       count_sat;
    logic [RC_W-1:0]       rem_after;
    logic [RI_W-1:0]       rem_idx;
    logic                  cur_bit;
    logic [BYTE_W-1:0]     new_byte;
    logic                  byte_done;
    logic                  keep;
    logic                  is_ff;
    logic                  more_after;
    logic                  more_now;
    logic                  at_limit;

    // Current code bit, MSB first
    assign count_sat  = (RC_W'(count) > RC_W'(MAX_CODE_BITS)) ? RC_W'(MAX_CODE_BITS)
                                                              : RC_W'(count);
    assign rem_after  = rem_reg - RC_W'(1);
    assign rem_idx    = rem_after[RI_W-1:0];
    assign cur_bit    = code_reg[rem_idx];
    assign new_byte   = {acc_reg, cur_bit};
    assign byte_done  = (acc_cnt_reg == ACC_FULL);
    assign keep       = (n_reg < RESULT_LIMIT);
    assign at_limit   = (n_reg == RESULT_LAST);
    assign is_ff      = (new_byte == BYTE_FF);
    assign more_after = (rem_after >= RC_W'(BYTE_W));
    assign more_now   = (rem_reg >= RC_W'(BYTE_W));

    assign in_stall = (state_reg != ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        rem_next     = rem_reg;
        flush_next   = flush_reg;
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        n_next       = n_reg;
        wr_req.wr    = 1'b0;
        wr_req.data  = new_byte;
        wr_req.last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                n_next = '0;
                if (in_valid)
                begin
                    if (mode == MODE_FLUSH)
                    begin
                        code_next  = SR_W'(PAD_VALUE);
                        rem_next   = RC_W'(PAD_BITS);
                        flush_next = 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else if (count_sat != '0)
                    begin
                        code_next  = SR_W'(value);
                        rem_next   = count_sat;
                        flush_next = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (rem_reg == '0)
                begin
                    // Flush leaves an empty residual
                    if (flush_reg)
                    begin
                        acc_cnt_next = '0;
                    end
                    state_next = ST_IDLE;
                end
                else if (!(byte_done && keep && !out_free))
                begin
                    rem_next = rem_after;
                    acc_next = {acc_reg[RES_W-2:0], cur_bit};
                    if (byte_done)
                    begin
                        acc_cnt_next = '0;
                        if (keep)
                        begin
                            wr_req.wr   = 1'b1;
                            wr_req.data = new_byte;
                            wr_req.last = (!is_ff && !more_after) || at_limit;
                            n_next      = n_reg + RESULT_W'(1);
                        end
                        if (is_ff)
                        begin
                            state_next = ST_STUFF;
                        end
                    end
                    else
                    begin
                        acc_cnt_next = acc_cnt_reg + ACC_CNT_W'(1);
                    end
                end
            end

            ST_STUFF:
            begin
                if (!keep)
                begin
                    state_next = ST_SHIFT;
                end
                else if (out_free)
                begin
                    wr_req.wr   = 1'b1;
                    wr_req.data = STUFF_BYTE;
                    wr_req.last = !more_now || at_limit;
                    n_next      = n_reg + RESULT_W'(1);
                    state_next  = ST_SHIFT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and residual state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            acc_cnt_reg <= '0;
            n_reg       <= '0;
            rem_reg     <= '0;
            flush_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            acc_cnt_reg <= acc_cnt_next;
            n_reg       <= n_next;
            rem_reg     <= rem_next;
            flush_reg   <= flush_next;
        end
    end

    // Code bits
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    jbp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_req    (wr_req),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// File: sv/jbp_out_stage.sv
// Output register stage: holds one result byte until the consumer takes it.
module jbp_out_stage
    import jbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  jbp_out_wr_t       wr_req,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // Slot is free when empty or being taken this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_req.wr)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (wr_req.wr)
        begin
            byte_reg <= wr_req.data;
            last_reg <= wr_req.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

endmodule

// File: sv/jbp_checker.sv
// Port-level checker for the bit packer, bound to the top level.
module jbp_checker
    import jbp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] out_byte,
    input logic              last
);

    logic                out_take;
    logic                ff_pend_reg;
    logic                ff_pend_next;
    logic [RESULT_W-1:0] run_reg;
    logic [RESULT_W-1:0] run_next;

    assign out_take = out_valid && !out_stall;

    // Track an unstuffed 0xFF and the length of the current run
    always_comb
    begin
        ff_pend_next = ff_pend_reg;
        run_next     = run_reg;
        if (out_take)
        begin
            ff_pend_next = (out_byte == BYTE_FF) && !last;
            run_next     = last ? '0 : (run_reg + RESULT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_pend_reg <= 1'b0;
            run_reg     <= '0;
        end
        else
        begin
            ff_pend_reg <= ff_pend_next;
            run_reg     <= run_next;
        end
    end

    // The packer only gets busy after an offered transaction
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without an offered transaction");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled output changed");

    // Valid drops only after a transaction
    a_out_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("output valid dropped without transaction");

    // A 0xFF inside a run is followed by a stuffed zero
    a_stuff: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && ff_pend_reg |-> out_byte == STUFF_BYTE)
        else $error("missing stuffed zero after 0xff");

    // No run exceeds the result limit
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !last |-> run_reg < RESULT_LAST)
        else $error("run longer than result limit");

endmodule

bind jpeg_bit_packer_stuffing jbp_checker u_jbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

// File: test/tb.sv
// Self-checking testbench for the JPEG bit packer with 0xFF byte stuffing.
module tb;
    import jbp_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_BITS     = MAX_CODE_BITS_DEF;
    localparam int RAND_ITEMS   = 290;
    localparam int HOLD_ITEMS   = 40;
    localparam int QUIET_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = MAX_BITS + 24;
    localparam int TIMEOUT_CYC  = 200000;
    localparam int NUM_DIR      = 24;

    // One expected stream byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } stream_byte_t;

    // One directed stimulus row; typed rows carry their bytes, first in the top byte
    typedef struct packed {
        logic [MODE_W-1:0]  m;
        logic [COUNT_W-1:0] c;
        logic [VALUE_W-1:0] v;
        logic               typed;
        logic [2:0]         n;
        logic [31:0]        bytes;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [BYTE_W-1:0]  out_byte;
    logic               last;

    // Predictor state: pending bits of the residual
    logic [RES_W-1:0]     res_bits;
    logic [ACC_CNT_W-1:0] res_cnt;

    stream_byte_t step_bytes[$];
    stream_byte_t expected_bytes[$];

    int  errors      = 0;
    int  items_sent  = 0;
    int  flushes     = 0;
    int  bytes_seen  = 0;
    bit  idle_on     = 1'b1;
    bit  hold_req    = 1'b0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{MODE_WRITE, 5'd8,  16'h00a5, 1'b1, 3'd1, 32'ha500_0000},
        '{MODE_WRITE, 5'd8,  16'h00ff, 1'b1, 3'd2, 32'hff00_0000},
        '{MODE_WRITE, 5'd16, 16'hffff, 1'b1, 3'd4, 32'hff00_ff00},
        '{MODE_WRITE, 5'd0,  16'hffff, 1'b1, 3'd0, 32'h0000_0000},
        '{MODE_FLUSH, 5'd0,  16'h0000, 1'b1, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd31, 16'h1234, 1'b1, 3'd2, 32'h1234_0000},
        '{MODE_WRITE, 5'd4,  16'hfff5, 1'b1, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd4,  16'h000a, 1'b1, 3'd1, 32'h5a00_0000},
        '{MODE_WRITE, 5'd1,  16'h0001, 1'b1, 3'd0, 32'h0000_0000},
        '{MODE_FLUSH, 5'd31, 16'hffff, 1'b1, 3'd2, 32'hff00_0000},
        '{MODE_WRITE, 5'd3,  16'h0005, 1'b1, 3'd0, 32'h0000_0000},
        '{MODE_FLUSH, 5'd0,  16'h0000, 1'b1, 3'd1, 32'hbf00_0000},
        '{MODE_WRITE, 5'd7,  16'h007f, 1'b1, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd1,  16'h0001, 1'b1, 3'd2, 32'hff00_0000},
        '{MODE_WRITE, 5'd16, 16'h0000, 1'b1, 3'd2, 32'h0000_0000},
        '{MODE_WRITE, 5'd17, 16'hffff, 1'b1, 3'd4, 32'hff00_ff00},
        '{MODE_WRITE, 5'd5,  16'h0015, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd13, 16'h1abc, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd16, 16'hffff, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_FLUSH, 5'd0,  16'h0000, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd2,  16'h0003, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd15, 16'h7fff, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_WRITE, 5'd11, 16'h07ff, 1'b0, 3'd0, 32'h0000_0000},
        '{MODE_FLUSH, 5'd9,  16'h5555, 1'b0, 3'd0, 32'h0000_0000}
    };

    jpeg_bit_packer_stuffing #(
        .MAX_CODE_BITS(MAX_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .count    (count),
        .value    (value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte (out_byte),
        .last     (last)
    );

    // Clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Pack one transaction into bytes with stuffing; results go to step_bytes
    function automatic void pack_code(input logic [MODE_W-1:0] m,
                                      input logic [COUNT_W-1:0] c,
                                      input logic [VALUE_W-1:0] v);
        logic [31:0]       acc;
        logic [31:0]       code;
        logic [BYTE_W-1:0] b;
        int                nb;
        int                total;
        int                n;
        stream_byte_t      sb;
        step_bytes.delete();
        n = 0;
        if (m == MODE_FLUSH)
        begin
            nb   = PAD_BITS;
            code = {24'd0, PAD_VALUE};
        end
        else
        begin
            nb   = (int'(c) > MAX_BITS) ? MAX_BITS : int'(c);
            code = {16'd0, v} & ((32'd1 << nb) - 32'd1);
        end
        acc   = ({25'd0, res_bits} << nb) | code;
        total = int'(res_cnt) + nb;
        // Emit completed bytes, MSB first, up to the result limit
        while (total >= 8)
        begin
            b = BYTE_W'(acc >> (total - 8));
            total -= 8;
            if (n < int'(RESULT_LIMIT))
            begin
                sb.data = b;
                sb.last = 1'b0;
                step_bytes.push_back(sb);
                n++;
            end
            if (b == BYTE_FF && n < int'(RESULT_LIMIT))
            begin
                sb.data = STUFF_BYTE;
                sb.last = 1'b0;
                step_bytes.push_back(sb);
                n++;
            end
        end
        if (n > 0)
            step_bytes[n-1].last = 1'b1;
        // Flush drops the residual, a write keeps the leftover bits
        if (m == MODE_FLUSH)
        begin
            res_bits = '0;
            res_cnt  = '0;
        end
        else
        begin
            res_cnt  = ACC_CNT_W'(total);
            res_bits = RES_W'(acc & ((32'd1 << total) - 32'd1));
        end
    endfunction

    // Offer one transaction, wait for acceptance, record the expected bytes
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [COUNT_W-1:0] c,
                             input logic [VALUE_W-1:0] v, input logic typed,
                             input logic [2:0] n, input logic [31:0] bytes);
        stream_byte_t sb;
        in_valid <= 1'b1;
        mode     <= m;
        count    <= c;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        pack_code(m, c, v);
        if (typed)
        begin
            for (int i = 0; i < int'(n); i++)
            begin
                sb.data = bytes[31 - 8*i -: 8];
                sb.last = (i == int'(n) - 1);
                expected_bytes.push_back(sb);
            end
        end
        else
        begin
            foreach (step_bytes[i])
                expected_bytes.push_back(step_bytes[i]);
        end
        items_sent++;
        if (m == MODE_FLUSH)
            flushes++;
        // Random gap after the transaction
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Random transaction: mostly legal codes, some flushes, zero and oversized counts
    task automatic send_random();
        logic [MODE_W-1:0]  m;
        logic [COUNT_W-1:0] c;
        logic [VALUE_W-1:0] v;
        int                 r;
        r = $urandom_range(0, 99);
        m = (r < 10) ? MODE_FLUSH : MODE_WRITE;
        if (r < 10)
            c = COUNT_W'($urandom);
        else if (r < 14)
            c = '0;
        else if (r < 20)
            c = COUNT_W'($urandom_range(MAX_BITS + 1, 31));
        else
            c = COUNT_W'($urandom_range(1, MAX_BITS));
        v = ($urandom_range(0, 9) < 3) ? '1 : VALUE_W'($urandom);
        send_item(m, c, v, 1'b0, 3'd0, 32'd0);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Output checker against the oldest expected byte
    always @(posedge clk)
    begin
        stream_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_seen++;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected byte: expected none, actual out_byte=%02h last=%b",
                         $time, out_byte, last);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, out_byte);
                end
                if (last !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, last);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYC);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_WRITE;
        count    <= '0;
        value    <= '0;
        res_bits = '0;
        res_cnt  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < NUM_DIR; i++)
            send_item(dir_rows[i].m, dir_rows[i].c, dir_rows[i].v,
                      dir_rows[i].typed, dir_rows[i].n, dir_rows[i].bytes);

        // Random traffic with idling on both sides
        repeat (RAND_ITEMS) send_random();

        // Long output hold-off while the sender keeps offering
        hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_random();

        // Final stretch with no idling
        idle_on = 1'b0;
        repeat (QUIET_ITEMS) send_random();
        in_valid <= 1'b0;

        // Drain
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transactions (%0d flushes), %0d stream bytes checked,",
                 items_sent, flushes, bytes_seen);
        $display("with random idling, one %0d-cycle output hold-off and a no-idle tail.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
